// ===== src/assert_macros.svh =====
// assertion helpers for the table block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock once out of reset
`define CHK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on the next clock
`define CHK_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== src/nktt_pkg.sv =====
// ----------------------------------------------------------------------------
// nktt_pkg
// types, constants and codes shared by the sorted key table modules
// ----------------------------------------------------------------------------
package nktt_pkg;

    localparam int CAPACITY = 1024;
    localparam int CAP_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 31;
    localparam int VAL_W    = 31;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_UPDATE = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK   = 3'd0,
        ST_NONE = 3'd1,
        ST_TIE  = 3'd2,
        ST_DUP  = 3'd3,
        ST_FULL = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH,
        S_SRCH_CMP,
        S_NB_WAIT,
        S_EVAL,
        S_UPD,
        S_VAL_RD,
        S_VAL_WAIT,
        S_SH_RD,
        S_SH_WR,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic srch_rd;
        logic srch_cmp;
        logic diff_ld;
        logic eval;
        logic upd_wr;
        logic val_take;
        logic sh_rd;
        logic sh_wr;
        logic ins_wr;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic srch_done;
        logic sh_done;
        logic eval_ok;
        logic out_free;
    } stat_t;

endpackage

// ===== src/nktt_ctrl.sv =====
// ----------------------------------------------------------------------------
// nktt_ctrl
// sequencer for search, shift-insert, update and query of the key table
// ----------------------------------------------------------------------------
module nktt_ctrl
    import nktt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  logic  op_nop,
    input  stat_t st,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = op_nop ? S_FINISH : S_SRCH;
                end
            end
            S_SRCH:
            begin
                if (st.srch_done)
                begin
                    state_next = S_NB_WAIT;
                end
                else
                begin
                    cmd.srch_rd = 1'b1;
                    state_next  = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP:
            begin
                cmd.srch_cmp = 1'b1;
                state_next   = S_SRCH;
            end
            S_NB_WAIT:
            begin
                cmd.diff_ld = 1'b1;
                state_next  = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.eval = 1'b1;
                if (!st.eval_ok)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    unique case (st.op)
                        OP_INSERT: state_next = S_SH_RD;
                        OP_UPDATE: state_next = S_UPD;
                        default:   state_next = S_VAL_RD;
                    endcase
                end
            end
            S_UPD:
            begin
                cmd.upd_wr = 1'b1;
                state_next = S_FINISH;
            end
            S_VAL_RD:
            begin
                state_next = S_VAL_WAIT;
            end
            S_VAL_WAIT:
            begin
                cmd.val_take = 1'b1;
                state_next   = S_FINISH;
            end
            S_SH_RD:
            begin
                if (st.sh_done)
                begin
                    cmd.ins_wr = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.sh_rd  = 1'b1;
                    state_next = S_SH_WR;
                end
            end
            S_SH_WR:
            begin
                cmd.sh_wr  = 1'b1;
                state_next = S_SH_RD;
            end
            S_FINISH:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// ===== src/nktt_dp.sv =====
// ----------------------------------------------------------------------------
// nktt_dp
// key and value memories, search registers, match logic and output register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nktt_dp
    import nktt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             cmd,
    output stat_t            st,
    output logic             op_nop,
    input  logic [1:0]       op,
    input  logic [KEY_W-1:0] search_key,
    input  logic [VAL_W-1:0] data_value,
    input  logic             wr_en,
    input  logic [KEY_W-1:0] wr_data,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [2:0]       status,
    output logic [VAL_W-1:0] read_value
);

    logic [KEY_W-1:0] key_mem [CAPACITY];
    logic [VAL_W-1:0] val_mem [CAPACITY];

    logic [KEY_W-1:0] tol_reg;
    logic [CNT_W-1:0] count_reg;
    op_t              op_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] val_reg;
    logic [CNT_W-1:0] lo_reg;
    logic [CNT_W-1:0] hi_reg;
    logic [CNT_W-1:0] p_reg;
    logic [CAP_W-1:0] idx_reg;
    logic [KEY_W-1:0] rw_reg;
    logic [KEY_W-1:0] lw_reg;
    logic             dup_reg;
    status_t          res_status_reg;
    logic [VAL_W-1:0] res_value_reg;
    logic             out_valid_reg;
    status_t          out_status_reg;
    logic [VAL_W-1:0] out_value_reg;

    logic [KEY_W-1:0] key_a_rd;
    logic [KEY_W-1:0] key_b_rd;
    logic [VAL_W-1:0] val_rd;

    logic [CNT_W-1:0] mid;
    logic [CNT_W-1:0] lo_m1;
    logic [CNT_W-1:0] p_m1;
    logic [CAP_W-1:0] addr_a;
    logic [CAP_W-1:0] addr_v;
    logic             has_r;
    logic             has_l;
    logic             full;
    status_t          eval_status;
    logic [CAP_W-1:0] eval_idx;

    assign mid   = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign lo_m1 = lo_reg - CNT_W'(1);
    assign p_m1  = p_reg - CNT_W'(1);
    assign has_r = lo_reg < count_reg;
    assign has_l = lo_reg != '0;
    assign full  = count_reg >= CNT_W'(CAPACITY);

    always_comb
    begin
        if (cmd.srch_rd)
        begin
            addr_a = mid[CAP_W-1:0];
        end
        else if (cmd.sh_rd)
        begin
            addr_a = p_m1[CAP_W-1:0];
        end
        else
        begin
            addr_a = lo_reg[CAP_W-1:0];
        end
        addr_v = cmd.sh_rd ? p_m1[CAP_W-1:0] : idx_reg;
    end

    // registered reads, one write port per memory
    always_ff @(posedge clk)
    begin
        key_a_rd <= key_mem[addr_a];
        key_b_rd <= key_mem[lo_m1[CAP_W-1:0]];
        val_rd   <= val_mem[addr_v];
        if (cmd.sh_wr)
        begin
            key_mem[p_reg[CAP_W-1:0]] <= key_a_rd;
            val_mem[p_reg[CAP_W-1:0]] <= val_rd;
        end
        else if (cmd.ins_wr)
        begin
            key_mem[lo_reg[CAP_W-1:0]] <= key_reg;
            val_mem[lo_reg[CAP_W-1:0]] <= val_reg;
        end
        else if (cmd.upd_wr)
        begin
            val_mem[idx_reg] <= val_reg;
        end
    end

    // nearest match decision on registered distances
    always_comb
    begin
        eval_status = ST_OK;
        eval_idx    = lo_reg[CAP_W-1:0];
        if (op_reg == OP_INSERT)
        begin
            if (dup_reg)
            begin
                eval_status = ST_DUP;
            end
            else if (full)
            begin
                eval_status = ST_FULL;
            end
        end
        else if (!has_r && !has_l)
        begin
            eval_status = ST_NONE;
        end
        else if (!has_l)
        begin
            if (rw_reg > tol_reg)
            begin
                eval_status = ST_NONE;
            end
        end
        else if (!has_r)
        begin
            eval_idx = lo_m1[CAP_W-1:0];
            if (lw_reg > tol_reg)
            begin
                eval_status = ST_NONE;
            end
        end
        else if (lw_reg > tol_reg && rw_reg > tol_reg)
        begin
            eval_status = ST_NONE;
        end
        else if (lw_reg < rw_reg)
        begin
            eval_idx = lo_m1[CAP_W-1:0];
        end
        else if (lw_reg == rw_reg)
        begin
            eval_status = ST_TIE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg         <= op_t'(op);
            key_reg        <= search_key;
            val_reg        <= data_value;
            res_status_reg <= ST_OK;
            res_value_reg  <= '0;
        end
        if (cmd.diff_ld)
        begin
            rw_reg  <= key_a_rd - key_reg;
            lw_reg  <= key_reg - key_b_rd;
            dup_reg <= has_r && (key_a_rd == key_reg);
        end
        if (cmd.eval)
        begin
            res_status_reg <= eval_status;
            idx_reg        <= eval_idx;
        end
        if (cmd.val_take)
        begin
            res_value_reg <= val_rd;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_value_reg  <= res_value_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg       <= '0;
            count_reg     <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            p_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                tol_reg <= wr_data;
            end
            if (cmd.load)
            begin
                lo_reg <= '0;
                hi_reg <= count_reg;
            end
            if (cmd.srch_cmp)
            begin
                if (key_a_rd < key_reg)
                begin
                    lo_reg <= mid + CNT_W'(1);
                end
                else
                begin
                    hi_reg <= mid;
                end
            end
            if (cmd.eval)
            begin
                p_reg <= count_reg;
            end
            if (cmd.sh_wr)
            begin
                p_reg <= p_m1;
            end
            if (cmd.ins_wr)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign op_nop       = op_t'(op) == OP_NOP;
    assign st.op        = op_reg;
    assign st.srch_done = lo_reg >= hi_reg;
    assign st.sh_done   = p_reg == lo_reg;
    assign st.eval_ok   = eval_status == ST_OK;
    assign st.out_free  = !out_valid_reg || !out_stall;

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign read_value = out_value_reg;

    `CHK_ALWAYS(a_count_cap, count_reg <= CNT_W'(CAPACITY), "entry count above capacity")
    `CHK_NEXT(a_ins_grow, cmd.ins_wr, count_reg == $past(count_reg) + CNT_W'(1), "insert lost")
    `CHK_ALWAYS(a_ins_room, !cmd.ins_wr || !full, "insert into full table")
    `CHK_ALWAYS(a_search_order, lo_reg <= hi_reg || !cmd.srch_cmp, "search bounds crossed")

endmodule

// ===== src/nearest_key_tolerance_table.sv =====
// ----------------------------------------------------------------------------
// nearest_key_tolerance_table
// sorted key/value table with insert, nearest-key update and query
// ----------------------------------------------------------------------------
// One item at a time. An item is accepted, runs a binary search over the key
// memory (a read and then a compare per halving) and goes on through the
// neighbor read, distance and decision steps to the result hand-off; an insert
// then shifts the entries above its slot, a read and a write per moved entry
// through the single write port, and then writes the new entry; an update adds
// a value write and a query a value read. A no-op skips to the hand-off. The
// result sits in an output register, so the next item is taken while it waits.
module nearest_key_tolerance_table
    import nktt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [1:0]       op,
    input  logic [KEY_W-1:0] search_key,
    input  logic [VAL_W-1:0] data_value,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [2:0]       status,
    output logic [VAL_W-1:0] read_value,
    input  logic             wr_en,
    input  logic [KEY_W-1:0] wr_data
);

    cmd_t  cmd;
    stat_t st;
    logic  op_nop;

    nktt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .op_nop   (op_nop),
        .st       (st),
        .cmd      (cmd)
    );

    nktt_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .st         (st),
        .op_nop     (op_nop),
        .op         (op),
        .search_key (search_key),
        .data_value (data_value),
        .wr_en      (wr_en),
        .wr_data    (wr_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .read_value (read_value)
    );

endmodule
